>>> rtl/mfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_pkg
// Shared types and constants for the minmod face reconstruction pipeline.
// ----------------------------------------------------------------------------
package mfr_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned DivSteps = 31;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TIME_STEP    = 1'b0,
    CFG_COURANT_MODE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] value_next;
    logic signed [31:0] value_center;
    logic signed [31:0] value_prev;
    logic [31:0]        cell_width;
    logic [31:0]        signal_speed;
    logic signed [31:0] cell_velocity;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] left_face;
    logic signed [31:0] right_face;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    cfg_idx_e    index;
    logic [31:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic signed [32:0] slope;
    logic signed [31:0] center;
    logic               use_c;
    logic               vneg;
  } side_t;

  typedef struct packed {
    logic [63:0] prod;
    logic [31:0] width;
    side_t       side;
  } div_in_t;

  typedef struct packed {
    logic        ovf;
    logic [30:0] quo;
    side_t       side;
  } div_out_t;

endpackage

>>> rtl/mfr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_if
// Valid/ready channels for input cells, result faces and register writes.
// ----------------------------------------------------------------------------
interface mfr_in_if;
  import mfr_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mfr_out_if;
  import mfr_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mfr_cfg_if;
  import mfr_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/mfr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_front
// Minmod slope, speed by time step product and factor selection.
// ----------------------------------------------------------------------------
module mfr_front import mfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  in_item_t item_i,
  input  logic [31:0] time_step_i,
  input  logic     mode_i,
  output logic     valid_o,
  output div_in_t  data_o
);

  logic signed [32:0] dm, dp, slope;
  div_in_t data_d, data_q;
  logic valid_q;

  always_comb begin
    dm = 33'(item_i.value_center) - 33'(item_i.value_prev);
    dp = 33'(item_i.value_next) - 33'(item_i.value_center);
    if (dp > 0) begin
      slope = (dm < dp) ? dm : dp;
      if (slope < 0) slope = '0;
    end else begin
      slope = (dm > dp) ? dm : dp;
      if (slope > 0) slope = '0;
    end
    data_d.prod        = 64'(item_i.signal_speed) * 64'(time_step_i);
    data_d.width       = item_i.cell_width;
    data_d.side.slope  = slope;
    data_d.side.center = item_i.value_center;
    data_d.side.use_c  = mode_i && (item_i.cell_velocity != '0);
    data_d.side.vneg   = item_i.cell_velocity[31];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> rtl/mfr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detection for quotients beyond the 31-bit factor range and for a zero width.
// ----------------------------------------------------------------------------
module mfr_div import mfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     valid_i,
  input  div_in_t  data_i,
  output logic     valid_o,
  output div_out_t data_o
);

  typedef struct packed {
    logic        ovf;
    logic [31:0] rem;
    logic [30:0] quo;
    logic [30:0] low;
    logic [31:0] width;
    side_t       side;
  } stg_t;

  stg_t stg_q [0:DivSteps];
  stg_t stg_d [0:DivSteps];
  logic [DivSteps:0] v_q;

  always_comb begin
    stg_d[0].ovf   = (data_i.width == '0) || ({1'b0, data_i.prod[63:31]} >=
                     {2'b0, data_i.width});
    stg_d[0].rem   = data_i.prod[62:31];
    stg_d[0].quo   = '0;
    stg_d[0].low   = data_i.prod[30:0];
    stg_d[0].width = data_i.width;
    stg_d[0].side  = data_i.side;
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [32:0] part, trial;
    always_comb begin
      part  = {stg_q[k].rem, stg_q[k].low[30]};
      trial = part - {1'b0, stg_q[k].width};
      stg_d[k+1]     = stg_q[k];
      stg_d[k+1].low = {stg_q[k].low[29:0], 1'b0};
      if (part >= {1'b0, stg_q[k].width}) begin
        stg_d[k+1].rem = trial[31:0];
        stg_d[k+1].quo = {stg_q[k].quo[29:0], 1'b1};
      end else begin
        stg_d[k+1].rem = part[31:0];
        stg_d[k+1].quo = {stg_q[k].quo[29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivSteps-1:0], valid_i};
    end
  end

  for (genvar s = 0; s <= DivSteps; s++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  assign valid_o     = v_q[DivSteps];
  assign data_o.ovf  = stg_q[DivSteps].ovf;
  assign data_o.quo  = stg_q[DivSteps].quo;
  assign data_o.side = stg_q[DivSteps].side;

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[DivSteps] && !stg_q[DivSteps].ovf) |->
      (stg_q[DivSteps].rem < stg_q[DivSteps].width))
    else $error("divider remainder not below divisor");
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && v_q[0]) |=> v_q[1])
    else $error("divider valid lost on advance");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(v_q))
    else $error("divider valids moved while stalled");

endmodule

>>> rtl/mfr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfr_back
// Courant factor, slope products and clipped face values.
// ----------------------------------------------------------------------------
module mfr_back import mfr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  div_out_t  data_i,
  output logic      valid_o,
  output out_item_t data_o
);

  localparam logic signed [33:0] One = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [66:0] SMax = 67'sd2147483647;
  localparam logic signed [66:0] SMin = -67'sd2147483648;

  // factor stage
  logic signed [33:0] c, fl, fr;
  logic [32:0] fla_d, fra_d, sa_d, fla_q, fra_q, sa_q;
  logic negl_d, negr_d, satc_d, negl_q, negr_q, satc_q;
  logic signed [31:0] cen_q1;
  logic v1_q;

  always_comb begin
    c      = '0;
    satc_d = 1'b0;
    if (data_i.side.use_c) begin
      c      = data_i.ovf ? 34'sd2147483647 : 34'($unsigned(data_i.quo));
      satc_d = data_i.ovf;
      if (data_i.side.vneg) c = -c;
    end
    fl     = One + c;
    fr     = One - c;
    fla_d  = fl[33] ? 33'(-fl) : fl[32:0];
    fra_d  = fr[33] ? 33'(-fr) : fr[32:0];
    sa_d   = data_i.side.slope[32] ? 33'(-data_i.side.slope)
                                   : data_i.side.slope;
    negl_d = fl[33] ^ data_i.side.slope[32];
    negr_d = fr[33] ^ data_i.side.slope[32];
  end

  // product stage
  logic [65:0] pl_q, pr_q;
  logic negl_q2, negr_q2, satc_q2, v2_q;
  logic signed [31:0] cen_q2;

  // face stage
  logic [65:0] ml, mr;
  logic signed [66:0] hl, hr, lw, rw;
  out_item_t out_d, out_q;
  logic v3_q;

  always_comb begin
    ml = pl_q >> (FRAC_BITS + 1);
    mr = pr_q >> (FRAC_BITS + 1);
    hl = negl_q2 ? -$signed({1'b0, ml}) : $signed({1'b0, ml});
    hr = negr_q2 ? -$signed({1'b0, mr}) : $signed({1'b0, mr});
    lw = 67'(cen_q2) - hl;
    rw = 67'(cen_q2) + hr;
    out_d.saturated = satc_q2;
    if (lw > SMax) begin
      out_d.left_face = 32'sh7fffffff; out_d.saturated = 1'b1;
    end else if (lw < SMin) begin
      out_d.left_face = 32'sh80000000; out_d.saturated = 1'b1;
    end else begin
      out_d.left_face = lw[31:0];
    end
    if (rw > SMax) begin
      out_d.right_face = 32'sh7fffffff; out_d.saturated = 1'b1;
    end else if (rw < SMin) begin
      out_d.right_face = 32'sh80000000; out_d.saturated = 1'b1;
    end else begin
      out_d.right_face = rw[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fla_q   <= fla_d;
      fra_q   <= fra_d;
      sa_q    <= sa_d;
      negl_q  <= negl_d;
      negr_q  <= negr_d;
      satc_q  <= satc_d;
      cen_q1  <= data_i.side.center;
      pl_q    <= 66'(fla_q) * 66'(sa_q);
      pr_q    <= 66'(fra_q) * 66'(sa_q);
      negl_q2 <= negl_q;
      negr_q2 <= negr_q;
      satc_q2 <= satc_q;
      cen_q2  <= cen_q1;
      out_q   <= out_d;
    end
  end

  assign valid_o = v3_q;
  assign data_o  = out_q;

endmodule

>>> rtl/minmod_face_reconstruct.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmod_face_reconstruct
// Minmod-limited face reconstruction with Courant correction, Q format.
// ----------------------------------------------------------------------------
// Pipeline: 1 front, 32 divider and 3 back stages; the divider resolves
// one quotient bit per stage.
// Throughput: one cell per cycle; every stage advances together while the
// output register is empty or being taken.
// Reset: pipeline empty, time_step 0, courant_mode 1.
module minmod_face_reconstruct import mfr_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  mfr_in_if.sink    in_i,
  mfr_out_if.source out_o,
  mfr_cfg_if.sink   cfg_i
);

  logic [31:0] time_step_q;
  logic        mode_q;
  logic        en;
  logic        f_valid, d_valid;
  div_in_t     f_data;
  div_out_t    d_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= '0;
      mode_q      <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        CFG_TIME_STEP:    time_step_q <= cfg_i.data.data;
        CFG_COURANT_MODE: mode_q      <= cfg_i.data.data[0];
        default: ;
      endcase
    end
  end

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  mfr_front u_front (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_i.valid), .item_i(in_i.data),
    .time_step_i(time_step_q), .mode_i(mode_q),
    .valid_o(f_valid), .data_o(f_data)
  );

  mfr_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .data_i(f_data),
    .valid_o(d_valid), .data_o(d_data)
  );

  mfr_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .en_i(en), .valid_i(d_valid), .data_i(d_data),
    .valid_o(out_o.valid), .data_o(out_o.data)
  );

endmodule
